FILE: hdl/srhs_pkg.sv
package srhs_pkg;

	localparam int SRHS_STEP_BITS = 16;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_CHECK = 2'd1,
		ACT_LOAD  = 2'd2
	} srhs_action_t;

	typedef enum logic [1:0] {
		CFG_INTERVAL = 2'd0,
		CFG_TARGET   = 2'd1,
		CFG_KIND     = 2'd2
	} srhs_cfg_idx_t;

	localparam logic [1:0] MODE_HOMING = 2'd2;
	localparam logic [1:0] KIND_HOMING = 2'd2;

	localparam logic [2:0] PH_SEEK     = 3'd1;
	localparam logic [2:0] PH_BACKOFF  = 3'd2;
	localparam logic [2:0] PH_APPROACH = 3'd3;
	localparam logic [2:0] PH_PARKED   = 3'd4;

	localparam logic [15:0] RST_INTERVAL = 16'd10;
	localparam logic [7:0]  RST_TARGET   = 8'd40;
	localparam logic [1:0]  RST_KIND     = 2'd2;

	localparam logic [7:0]  SPEED_MIN   = 8'd1;
	localparam logic [7:0]  SPEED_FLOOR = 8'd5;
	localparam logic [13:0] DECEL_MULT  = 14'd50;
	localparam logic [19:0] TIME_MULT   = 20'd10;
	localparam logic [15:0] BACKOFF_STEPS = 16'd2000;
	localparam logic [15:0] FULL_STEPS    = 16'hFFFF;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 32;

endpackage

FILE: hdl/stepper_ramp_homing_sequencer.sv
// Stepper step generator with speed ramp and sensor homing sequence.
// Input stream (s_*): one request per item. s_tuser carries the action
// (pulse tick, control check, load move); s_tdata carries the time stamp,
// sensor, mode, step count and phase. Output stream (m_*): exactly one
// result per input request; m_tlast marks the step that finished a move.
// Configuration writes (cfg_*) are always ready and take effect at once;
// write them only while no request is in flight.
// Pipeline: two-stage; a request is captured in the input register and its
// result in the result register, from which it is shown on m_*.
// Throughput: one request per cycle while m_tready is high; the motion state is updated by
// combinational logic (a 32x8 multiply and compare) between the two
// registers, so back-to-back requests see each other's updates.
// When m_tready is low the result register holds; the input register
// still accepts one more request, after which s_tready drops.
// Reset (arst_n low) clears both streams and sets the motion state to
// zero steps, speed 1, phase 0, and the registers to their defaults.
module stepper_ramp_homing_sequencer #(
	parameter int STEP_COUNT_BITS = srhs_pkg::SRHS_STEP_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// now_ms[31:0], sensor_hit[32], mode_code[34:33], step_load[50:35], phase_load[53:51]
	input  logic [srhs_pkg::IN_TDATA_W-1:0]    s_tdata,
	// action[1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// step_level[0], dir_level[1], steps_left[17:2], speed_now[25:18],
	// phase_now[28:26], step_taken[29]
	output logic [srhs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// move_done
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [15:0]                        cfg_data
);
	import srhs_pkg::*;

	localparam int W = STEP_COUNT_BITS;
	localparam logic [W-1:0] RELOAD_FULL  = (W >= 16) ? W'(FULL_STEPS) : {W{1'b1}};
	localparam logic [W-1:0] RELOAD_BACK  = W'(BACKOFF_STEPS);

	logic [15:0] interval_q;
	logic [7:0]  target_q;
	logic [1:0]  kind_q;

	logic         valid_s1;
	logic [1:0]   action_s1;
	logic [31:0]  now_s1;
	logic         sensor_s1;
	logic [1:0]   mode_s1;
	logic [15:0]  load_s1;
	logic [2:0]   phase_ld_s1;

	logic [W-1:0] rem_q;
	logic [7:0]   speed_q;
	logic         pulse_q;
	logic [31:0]  last_q;
	logic         stop_q;
	logic [2:0]   phase_q;
	logic         dir_q;

	logic [W-1:0] rem_n;
	logic [7:0]   speed_n;
	logic         pulse_n;
	logic [31:0]  last_n;
	logic         stop_n;
	logic [2:0]   phase_n;
	logic         dir_n;
	logic         taken_n;
	logic         done_n;

	logic [W-1:0] rem_dec;
	logic [31:0]  elapsed;
	logic [39:0]  time_lhs;
	logic [19:0]  time_rhs;
	logic [13:0]  speed50;
	logic         homing;
	logic [31:0]  rem_ext;

	logic         advance;
	logic         out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic         out_last_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= RST_INTERVAL;
			target_q   <= RST_TARGET;
			kind_q     <= RST_KIND;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INTERVAL: interval_q <= cfg_data;
				CFG_TARGET:   target_q   <= cfg_data[7:0];
				CFG_KIND:     kind_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1   <= s_tuser;
			now_s1      <= s_tdata[31:0];
			sensor_s1   <= s_tdata[32];
			mode_s1     <= s_tdata[34:33];
			load_s1     <= s_tdata[50:35];
			phase_ld_s1 <= s_tdata[53:51];
		end
	end

	always_comb begin
		rem_n    = rem_q;
		speed_n  = speed_q;
		pulse_n  = pulse_q;
		last_n   = last_q;
		stop_n   = stop_q;
		phase_n  = phase_q;
		dir_n    = dir_q;
		taken_n  = 1'b0;
		done_n   = 1'b0;
		rem_dec  = rem_q - W'(1);
		elapsed  = now_s1 - last_q;
		time_lhs = 40'(elapsed) * 40'(target_q);
		time_rhs = 20'(interval_q) * TIME_MULT;
		speed50  = 14'(speed_q) * DECEL_MULT;
		homing   = (mode_s1 == MODE_HOMING) && (kind_q == KIND_HOMING);

		unique case (action_s1)
			ACT_TICK: begin
				if (rem_q != '0) begin
					pulse_n = ~pulse_q;
					if (pulse_q) begin
						rem_n   = rem_dec;
						taken_n = 1'b1;
						if (time_lhs >= 40'(time_rhs)) begin
							last_n = now_s1;
							if (33'(speed50) > 33'(rem_dec)) begin
								speed_n = (speed_q <= SPEED_FLOOR) ? SPEED_FLOOR
								                                  : speed_q - 8'd1;
							end else if (speed_q < target_q) begin
								speed_n = speed_q + 8'd1;
							end
						end
						if (rem_dec == '0) begin
							stop_n  = 1'b1;
							speed_n = SPEED_MIN;
							done_n  = 1'b1;
						end
					end
				end
			end
			ACT_CHECK: begin
				if (stop_q) begin
					stop_n  = 1'b0;
					dir_n   = 1'b0;
					speed_n = SPEED_MIN;
					if (homing && phase_q != PH_PARKED)
						phase_n = phase_q + 3'd1;
				end
				if (homing) begin
					priority if (sensor_s1 && rem_q == '0 && phase_n == PH_SEEK) begin
						dir_n   = 1'b1;
						rem_n   = RELOAD_BACK;
						phase_n = PH_BACKOFF;
					end else if (!sensor_s1 && phase_n <= PH_APPROACH && rem_q == '0) begin
						dir_n   = 1'b0;
						rem_n   = RELOAD_FULL;
						phase_n = PH_APPROACH;
					end else if (rem_q != '0 && sensor_s1 && phase_n == PH_APPROACH) begin
						rem_n   = '0;
						phase_n = PH_PARKED;
						speed_n = SPEED_MIN;
					end else begin
					end
				end
			end
			ACT_LOAD: begin
				rem_n   = W'(load_s1);
				phase_n = phase_ld_s1;
			end
			default: ;
		endcase
		rem_ext = 32'(rem_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			speed_q <= SPEED_MIN;
			pulse_q <= 1'b0;
			last_q  <= '0;
			stop_q  <= 1'b0;
			phase_q <= '0;
			dir_q   <= 1'b0;
		end else if (advance) begin
			rem_q   <= rem_n;
			speed_q <= speed_n;
			pulse_q <= pulse_n;
			last_q  <= last_n;
			stop_q  <= stop_n;
			phase_q <= phase_n;
			dir_q   <= dir_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, taken_n, phase_n, speed_n, rem_ext[15:0], dir_n, pulse_n};
			out_last_q <= done_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: hdl/srhs_checker.sv
module srhs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [srhs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);
	import srhs_pkg::*;

	// stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// finished move: a step was taken and speed fell back to minimum
	a_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[29] && (m_tdata[25:18] == SPEED_MIN))
		else $error("move done without step or speed reset");

	// a step completes only on the falling edge of the pulse line
	a_step_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> !m_tdata[0])
		else $error("step taken with pulse line high");

endmodule

bind stepper_ramp_homing_sequencer srhs_checker u_srhs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import srhs_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic        step_level;
		logic        dir_level;
		logic [15:0] steps_left;
		logic [7:0]  speed_now;
		logic [2:0]  phase_now;
		logic        step_taken;
		logic        move_done;
	} motor_out_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [15:0]            cfg_data = '0;

	// predicted registers and motion state
	logic [15:0]               interval_reg = RST_INTERVAL;
	logic [7:0]                target_reg = RST_TARGET;
	logic [1:0]                kind_reg = RST_KIND;
	logic [SRHS_STEP_BITS-1:0] steps_rem = '0;
	logic [7:0]                speed = SPEED_MIN;
	logic                      pulse = 1'b0;
	logic [31:0]               last_ramp_ms = '0;
	logic                      stop_flag = 1'b0;
	logic [2:0]                phase = '0;
	logic                      dir = 1'b0;

	motor_out_t  expected_outs[$];
	logic [31:0] clock_ms = '0;
	int          snd_idle = 30;
	int          rcv_idle = 61;
	int          items_sent = 0;
	int          results_seen = 0;
	int          moves_done = 0;
	int          reg_writes = 0;
	int          mismatches = 0;
	int          stall_cycles = 0;

	stepper_ramp_homing_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic motor_out_t motor_step(input logic [1:0] act, input logic [31:0] now,
			input logic sensor, input logic [1:0] mode, input logic [15:0] load,
			input logic [2:0] ph);
		motor_out_t r;
		logic [31:0] elapsed;
		logic [63:0] lhs;
		logic homing;
		r.step_taken = 1'b0;
		r.move_done = 1'b0;
		case (act)
			ACT_TICK: begin
				if (steps_rem != '0) begin
					pulse = ~pulse;
					if (!pulse) begin
						steps_rem = steps_rem - 1'b1;
						elapsed = now - last_ramp_ms;
						lhs = 64'(elapsed) * 64'(target_reg);
						if (lhs >= 64'(interval_reg) * 64'(TIME_MULT)) begin
							if (32'(DECEL_MULT) * 32'(speed) > 32'(steps_rem)) begin
								speed = (speed <= SPEED_FLOOR) ? SPEED_FLOOR : speed - 8'd1;
							end else if (speed < target_reg) begin
								speed = speed + 8'd1;
							end
							last_ramp_ms = now;
						end
						r.step_taken = 1'b1;
						if (steps_rem == '0) begin
							stop_flag = 1'b1;
							speed = SPEED_MIN;
							r.move_done = 1'b1;
						end
					end
				end
			end
			ACT_CHECK: begin
				homing = (mode == MODE_HOMING) && (kind_reg == KIND_HOMING);
				if (stop_flag) begin
					stop_flag = 1'b0;
					dir = 1'b0;
					speed = SPEED_MIN;
					if (homing && phase != PH_PARKED)
						phase = phase + 3'd1;
				end
				if (homing) begin
					if (sensor && steps_rem == '0 && phase == PH_SEEK) begin
						dir = 1'b1;
						steps_rem = SRHS_STEP_BITS'(BACKOFF_STEPS);
						phase = PH_BACKOFF;
					end else if (!sensor && phase <= PH_APPROACH && steps_rem == '0) begin
						dir = 1'b0;
						steps_rem = SRHS_STEP_BITS'(FULL_STEPS);
						phase = PH_APPROACH;
					end else if (steps_rem != '0 && sensor && phase == PH_APPROACH) begin
						steps_rem = '0;
						phase = PH_PARKED;
						speed = SPEED_MIN;
					end
				end
			end
			ACT_LOAD: begin
				steps_rem = SRHS_STEP_BITS'(load);
				phase = ph;
			end
			default: ;
		endcase
		r.step_level = pulse;
		r.dir_level = dir;
		r.steps_left = 16'(steps_rem);
		r.speed_now = speed;
		r.phase_now = phase;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		motor_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_outs.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = expected_outs.pop_front();
				check_field("step_level", 16'(want.step_level), 16'(m_tdata[0]));
				check_field("dir_level", 16'(want.dir_level), 16'(m_tdata[1]));
				check_field("steps_left", want.steps_left, m_tdata[17:2]);
				check_field("speed_now", 16'(want.speed_now), 16'(m_tdata[25:18]));
				check_field("phase_now", 16'(want.phase_now), 16'(m_tdata[28:26]));
				check_field("step_taken", 16'(want.step_taken), 16'(m_tdata[29]));
				check_field("move_done", 16'(want.move_done), 16'(m_tlast));
				if (m_tlast)
					moves_done++;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] act, input logic [31:0] now, input logic sensor,
			input logic [1:0] mode, input logic [15:0] load, input logic [2:0] ph);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		// phase_load, step_load, mode_code, sensor_hit, now_ms
		s_tdata <= {2'b00, ph, load, mode, sensor, now};
		do @(posedge clk); while (!s_tready);
		expected_outs.push_back(motor_step(act, now, sensor, mode, load, ph));
		items_sent++;
	endtask

	task automatic send_tick();
		if ($urandom_range(99) < 3)
			clock_ms = $urandom();
		else
			clock_ms = clock_ms + $urandom_range(0, 9);
		send_req(ACT_TICK, clock_ms, 1'($urandom_range(1)), 2'($urandom_range(3)),
			16'($urandom()), 3'($urandom_range(7)));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_tick();
	endtask

	task automatic send_check(input logic sensor, input logic [1:0] mode);
		send_req(ACT_CHECK, $urandom(), sensor, mode, 16'($urandom()), 3'($urandom_range(7)));
	endtask

	task automatic send_load(input logic [15:0] steps, input logic [2:0] ph);
		send_req(ACT_LOAD, $urandom(), 1'($urandom_range(1)), 2'($urandom_range(3)), steps, ph);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_outs.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_INTERVAL: interval_reg = val;
			CFG_TARGET:   target_reg = val[7:0];
			CFG_KIND:     kind_reg = val[1:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] interval, input logic [7:0] target,
			input logic [1:0] kind);
		drain_results();
		write_reg(CFG_INTERVAL, interval);
		write_reg(CFG_TARGET, 16'(target));
		write_reg(CFG_KIND, 16'(kind));
	endtask

	task automatic run_move(input int n, input logic [2:0] ph, input logic [1:0] mode);
		send_load(16'(n), ph);
		send_ticks(2 * n + $urandom_range(0, 3));
		send_check($urandom_range(3) != 0, mode);
	endtask

	task automatic run_homing();
		int n;
		n = $urandom_range(1, 8);
		send_load(16'd0, ($urandom_range(3) != 0) ? PH_SEEK : 3'($urandom_range(3)));
		send_check(1'b1, MODE_HOMING);
		send_ticks($urandom_range(0, 6));
		send_load(16'(n), PH_BACKOFF);
		send_ticks(2 * n + $urandom_range(0, 2));
		send_check($urandom_range(4) == 0, MODE_HOMING);
		send_ticks($urandom_range(0, 8));
		send_check($urandom_range(4) != 0, MODE_HOMING);
		send_check(1'($urandom_range(1)), MODE_HOMING);
	endtask

	task automatic test_directed();
		send_tick();
		send_req(ACT_SPARE, '1, 1'b1, 2'b11, '1, 3'b111);
		clock_ms = 32'hFFFF_FFF8;
		send_load(16'd2, 3'd0);
		send_ticks(4);
		// stop consumed, seek advances straight into the full approach reload
		send_check(1'b0, MODE_HOMING);
		send_check(1'b1, MODE_HOMING);
		send_load(16'd0, PH_SEEK);
		send_check(1'b1, MODE_HOMING);
		// phase above parked wraps on the next consumed stop
		send_load(16'd2, 3'd7);
		send_ticks(4);
		send_check(1'b0, MODE_HOMING);
		send_load(16'hFFFF, PH_PARKED);
		send_check(1'b1, 2'd0);
		send_load(16'd0, PH_PARKED);
		send_check(1'b0, MODE_HOMING);
		send_check(1'b1, 2'b11);
	endtask

	task automatic test_register_extremes();
		set_config(16'd0, 8'd0, KIND_HOMING);
		run_move(6, 3'd0, MODE_HOMING);
		set_config(16'hFFFF, 8'd0, KIND_HOMING);
		run_move(6, PH_SEEK, MODE_HOMING);
		set_config(16'd0, 8'd255, KIND_HOMING);
		run_move(120, 3'd0, MODE_HOMING);
		set_config(16'hFFFF, 8'd255, 2'd0);
		run_homing();
		set_config(16'd1, 8'd1, 2'd1);
		run_homing();
		set_config(16'd25, 8'd100, 2'd3);
		run_homing();
		run_move(10, PH_APPROACH, MODE_HOMING);
		set_config(RST_INTERVAL, RST_TARGET, RST_KIND);
		run_homing();
	endtask

	task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
		int stop_at;
		int pick;
		int n;
		snd_idle = snd_pct;
		rcv_idle = rcv_pct;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				n = ($urandom_range(99) < 4) ? $urandom_range(100, 200) : $urandom_range(1, 30);
				run_move(n, ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4)),
					($urandom_range(3) != 0) ? MODE_HOMING : 2'($urandom_range(3)));
			end else if (pick < 75) begin
				run_homing();
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4))
					send_req(2'($urandom_range(3)), $urandom(), 1'($urandom_range(1)),
						2'($urandom_range(3)), 16'($urandom()), 3'($urandom_range(7)));
			end else if (pick < 96) begin
				send_load(16'($urandom_range(1, 20)), 3'($urandom_range(7)));
				send_ticks($urandom_range(0, 10));
				send_check(1'($urandom_range(1)), 2'($urandom_range(3)));
			end else begin
				drain_results();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_register_extremes();
		test_random(410, 30, 61);
		set_config(16'($urandom_range(0, 60)), 8'($urandom_range(1, 255)), KIND_HOMING);
		test_random(410, 61, 30);
		set_config(16'($urandom_range(0, 30)), 8'($urandom_range(20, 120)),
			($urandom_range(3) != 0) ? KIND_HOMING : 2'($urandom_range(3)));
		test_random(410, 0, 0);
		drain_results();
		repeat (8) @(posedge clk);
		$display("run: %0d requests, %0d results, %0d completed moves", items_sent,
			results_seen, moves_done);
		$display("run: %0d register writes over extreme and random ramp and homing settings",
			reg_writes);
		if (mismatches == 0 && expected_outs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
